FILE: hdl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    // Width of the internal decoded-byte counter
    localparam int LEN_BITS = 32;

    // Most results one input byte can cause
    localparam int MAX_RES = 6;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNFINISHED = 3'd1;
    localparam logic [2:0] ERR_ESCAPE     = 3'd2;
    localparam logic [2:0] ERR_HEX        = 3'd3;
    localparam logic [2:0] ERR_CONTROL    = 3'd4;
    localparam logic [2:0] ERR_UTF8       = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd6;

    // Long header needed once the length passes this
    localparam logic [31:0] SHORT_MAX = 32'd126;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [2:0]  error_code;
        logic [31:0] string_length;
        logic        long_header;
        logic        last;
    } out_item_t;

endpackage

FILE: hdl/json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps

// JSON string body unescaper: feed the bytes after the opening quote, one per
// beat, and it returns the unescaped UTF-8 bytes, then one done beat carrying
// the decoded length (and the long-header flag) on the closing quote, or one
// error beat. A byte that yields at most one result is taken every cycle while
// out_ready is high; a byte that yields more (up to six, e.g. a held high
// surrogate flushed ahead of a 3-byte \uXXXX) holds up the next byte, as the
// result buffer hands out one beat per cycle while out_ready is high and the
// next byte is taken as its last beat leaves. A byte that yields nothing
// (backslash, hex digit) leaves it empty. After done or error every byte but
// a quote is dropped; a quote starts a new string. validate_utf8 must be
// written on the cfg channel while the block is idle; nothing enforces it.
module json_string_unescape_utf8_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jsu_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jsu_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESCAPE,
        PH_HEX,
        PH_FOLLOW,
        PH_WAIT
    } phase_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    phase_t          phase_reg, phase_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [15:0]     hex_value_reg, hex_value_next;
    logic [9:0]      held_reg, held_next;
    logic            held_valid_reg, held_valid_next;
    logic [1:0]      follow_reg, follow_next;
    logic [LEN_BITS-1:0] count_reg, count_next;
    logic            validate_reg;

    out_item_t       res_reg [MAX_RES];
    out_item_t       res_next [MAX_RES];
    logic [2:0]      cnt_reg, cnt_next;
    logic [2:0]      idx_reg;

    logic            take_out;
    logic            out_last;
    logic            take_in;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic out_item_t mk_data(input logic [7:0] b);
        out_item_t r;
        r = '0;
        r.out_kind = KIND_DATA;
        r.out_byte = b;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_last  = (idx_reg == 3'(cnt_reg - 3'd1));
    assign take_out  = out_valid && out_ready;
    assign in_ready  = (cnt_reg == 3'd0) || (take_out && out_last);
    assign take_in   = in_valid && in_ready;

    always_comb
    begin
        out_data = res_reg[idx_reg];
        out_data.last = out_last;
    end

    always_comb
    begin : decode
        logic [7:0]  c;
        logic [7:0]  pay [4];
        logic [2:0]  np;
        logic        do_flush;
        logic        done_f;
        logic        err_f;
        logic [2:0]  err_c;
        logic [4:0]  hd;
        logic [15:0] v;
        logic [20:0] cp;
        logic [2:0]  n;
        logic [LEN_BITS:0] sum;
        logic [LEN_BITS-1:0] sat;
        out_item_t   tail;

        c = in_data.in_byte;
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        hex_value_next  = hex_value_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        follow_next     = follow_reg;
        count_next      = count_reg;
        for (int i = 0; i < 4; i++)
        begin
            pay[i] = 8'h00;
        end
        np       = 3'd0;
        do_flush = 1'b0;
        done_f   = 1'b0;
        err_f    = 1'b0;
        err_c    = ERR_NONE;
        hd       = hex_digit(c);
        v        = {hex_value_reg[11:0], hd[3:0]};
        cp       = {1'b0, held_reg, v[9:0]} + 21'h10000;

        if (phase_reg == PH_WAIT)
        begin
            if (!in_data.stream_end && c == CH_QUOTE)
            begin
                phase_next      = PH_NORMAL;
                hex_count_next  = 2'd0;
                hex_value_next  = 16'h0000;
                held_next       = 10'd0;
                held_valid_next = 1'b0;
                follow_next     = 2'd0;
                count_next      = '0;
            end
        end
        else if (in_data.stream_end)
        begin
            err_f = 1'b1;
            case (phase_reg)
                PH_ESCAPE: err_c = ERR_ESCAPE;
                PH_FOLLOW: err_c = ERR_TRUNCATED;
                default:   err_c = ERR_UNFINISHED;
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_ESCAPE:
                begin
                    phase_next = PH_NORMAL;
                    do_flush   = 1'b1;
                    np         = 3'd1;
                    case (c)
                        CH_QUOTE, CH_SLASH, CH_BSLASH: pay[0] = c;
                        CH_B: pay[0] = 8'h08;
                        CH_F: pay[0] = 8'h0c;
                        CH_N: pay[0] = 8'h0a;
                        CH_R: pay[0] = 8'h0d;
                        CH_T: pay[0] = 8'h09;
                        CH_U:
                        begin
                            do_flush       = 1'b0;
                            np             = 3'd0;
                            hex_count_next = 2'd0;
                            hex_value_next = 16'h0000;
                            phase_next     = PH_HEX;
                        end
                        default:
                        begin
                            do_flush = 1'b0;
                            np       = 3'd0;
                            err_f    = 1'b1;
                            err_c    = ERR_ESCAPE;
                        end
                    endcase
                end
                PH_HEX:
                begin
                    if (!hd[4])
                    begin
                        err_f = 1'b1;
                        err_c = ERR_HEX;
                    end
                    else if (hex_count_reg != 2'd3)
                    begin
                        hex_count_next = 2'(hex_count_reg + 2'd1);
                        hex_value_next = v;
                    end
                    else
                    begin
                        hex_count_next = 2'd0;
                        hex_value_next = 16'h0000;
                        phase_next     = PH_NORMAL;
                        if (v inside {[16'hdc00:16'hdfff]} && held_valid_reg)
                        begin
                            // merge pending high surrogate into one 4-byte form
                            held_valid_next = 1'b0;
                            held_next       = 10'd0;
                            np     = 3'd4;
                            pay[0] = 8'hf0 + {5'd0, cp[20:18]};
                            pay[1] = {2'b10, cp[17:12]};
                            pay[2] = {2'b10, cp[11:6]};
                            pay[3] = {2'b10, cp[5:0]};
                        end
                        else
                        begin
                            do_flush        = 1'b1;
                            held_valid_next = 1'b0;
                            held_next       = 10'd0;
                            if (v < 16'h0080)
                            begin
                                np     = 3'd1;
                                pay[0] = v[7:0];
                            end
                            else if (v < 16'h0800)
                            begin
                                np     = 3'd2;
                                pay[0] = {3'b110, v[10:6]};
                                pay[1] = {2'b10, v[5:0]};
                            end
                            else if (v inside {[16'hd800:16'hdbff]})
                            begin
                                // hold back: merged with a following low surrogate, else flushed or dropped on error
                                held_next       = v[9:0];
                                held_valid_next = 1'b1;
                            end
                            else
                            begin
                                np     = 3'd3;
                                pay[0] = {4'b1110, v[15:12]};
                                pay[1] = {2'b10, v[11:6]};
                                pay[2] = {2'b10, v[5:0]};
                            end
                        end
                    end
                end
                PH_FOLLOW:
                begin
                    if (c[7:6] != 2'b10)
                    begin
                        err_f = 1'b1;
                        err_c = ERR_UTF8;
                    end
                    else
                    begin
                        np          = 3'd1;
                        pay[0]      = c;
                        follow_next = 2'(follow_reg - 2'd1);
                        if (follow_reg == 2'd1)
                        begin
                            phase_next = PH_NORMAL;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_NORMAL;
                    if (c == CH_BSLASH)
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        do_flush   = 1'b1;
                        done_f     = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    else if (c < 8'h20)
                    begin
                        err_f = 1'b1;
                        err_c = ERR_CONTROL;
                    end
                    else if (c < 8'h80 || !validate_reg)
                    begin
                        do_flush = 1'b1;
                        np       = 3'd1;
                        pay[0]   = c;
                    end
                    else if (c inside {[8'hc0:8'hf7]})
                    begin
                        do_flush   = 1'b1;
                        np         = 3'd1;
                        pay[0]     = c;
                        phase_next = PH_FOLLOW;
                        if (c < 8'he0)
                        begin
                            follow_next = 2'd1;
                        end
                        else if (c < 8'hf0)
                        begin
                            follow_next = 2'd2;
                        end
                        else
                        begin
                            follow_next = 2'd3;
                        end
                    end
                    else
                    begin
                        err_f = 1'b1;
                        err_c = ERR_UTF8;
                    end
                end
            endcase
        end

        if (err_f)
        begin
            // drop any held surrogate
            phase_next      = PH_WAIT;
            held_valid_next = 1'b0;
            held_next       = 10'd0;
        end

        // assemble result list: flushed surrogate, payload bytes, then tail
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = '0;
        end
        n = 3'd0;
        if (do_flush && held_valid_reg)
        begin
            if (!(phase_reg == PH_HEX && held_valid_next))
            begin
                held_valid_next = 1'b0;
                held_next       = 10'd0;
            end
            res_next[0] = mk_data(8'hed);
            res_next[1] = mk_data({4'b1010, held_reg[9:6]});
            res_next[2] = mk_data({2'b10, held_reg[5:0]});
            n = 3'd3;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < np)
            begin
                res_next[n] = mk_data(pay[i]);
                n = 3'(n + 3'd1);
            end
        end

        sum = {1'b0, count_reg} + (LEN_BITS + 1)'(n);
        sat = sum[LEN_BITS] ? {LEN_BITS{1'b1}} : sum[LEN_BITS-1:0];
        if (phase_reg != PH_WAIT)
        begin
            count_next = sat;
        end

        tail = '0;
        if (done_f)
        begin
            tail.out_kind      = KIND_DONE;
            tail.string_length = 32'(sat);
            tail.long_header   = (32'(sat) > SHORT_MAX);
        end
        else
        begin
            tail.out_kind   = KIND_ERROR;
            tail.error_code = err_c;
        end
        if (done_f || err_f)
        begin
            res_next[n] = tail;
            n = 3'(n + 3'd1);
        end
        cnt_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_NORMAL;
            hex_count_reg  <= 2'd0;
            hex_value_reg  <= 16'h0000;
            held_reg       <= 10'd0;
            held_valid_reg <= 1'b0;
            follow_reg     <= 2'd0;
            count_reg      <= '0;
            validate_reg   <= 1'b0;
            cnt_reg        <= 3'd0;
            idx_reg        <= 3'd0;
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                validate_reg <= cfg_data;
            end
            if (take_in)
            begin
                phase_reg      <= phase_next;
                hex_count_reg  <= hex_count_next;
                hex_value_reg  <= hex_value_next;
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                follow_reg     <= follow_next;
                count_reg      <= count_next;
                cnt_reg        <= cnt_next;
                idx_reg        <= 3'd0;
                for (int i = 0; i < MAX_RES; i++)
                begin
                    res_reg[i] <= res_next[i];
                end
            end
            else if (take_out)
            begin
                // advance to the next result, or empty the buffer after the last
                if (out_last)
                begin
                    cnt_reg <= 3'd0;
                    idx_reg <= 3'd0;
                end
                else
                begin
                    idx_reg <= 3'(idx_reg + 3'd1);
                end
            end
        end
    end

endmodule

FILE: hdl/jsu_checker.sv
`timescale 1ns / 1ps

module jsu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input jsu_pkg::out_item_t out_data
);
    import jsu_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.out_kind == KIND_DONE || out_data.out_kind == KIND_ERROR)
        |-> out_data.last)
        else $error("done or error beat not last");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_kind == KIND_DATA
        |-> out_data.error_code == ERR_NONE && out_data.string_length == 32'd0
            && !out_data.long_header)
        else $error("data beat carries done or error fields");

    a_long_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_kind == KIND_DONE
        |-> out_data.long_header == (out_data.string_length > SHORT_MAX))
        else $error("long header flag disagrees with length");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("input taken while results still pending");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: tb/tb_json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_top;

    import jsu_pkg::*;

    localparam logic [7:0] QUOTE  = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5c;

    typedef enum logic [2:0] {ST_TEXT, ST_ESCAPE, ST_HEX, ST_UTF8, ST_WAIT} parse_st_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    // Predicted decoder state
    parse_st_t   st          = ST_TEXT;
    logic [2:0]  hex_digits  = '0;
    logic [15:0] hex_acc     = '0;
    logic [15:0] pend_hi     = '0;
    logic        pend_ok     = 1'b0;
    logic [1:0]  follow_cnt  = '0;
    logic [31:0] decoded_len = '0;
    logic        validate_on = 1'b0;

    out_item_t expected_q[$];

    bit idling_on   = 1'b1;
    int items_sent  = 0;
    int beats_seen  = 0;
    int done_seen   = 0;
    int long_seen   = 0;
    int errors_seen = 0;
    int mismatches  = 0;

    json_string_unescape_utf8_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void push_beat(logic [1:0] kind, logic [7:0] b, logic [2:0] code,
                                      logic [31:0] len, logic lng);
        out_item_t r;
        r.out_kind      = kind;
        r.out_byte      = b;
        r.error_code    = code;
        r.string_length = len;
        r.long_header   = lng;
        r.last          = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        push_beat(KIND_DATA, b, ERR_NONE, '0, 1'b0);
        if (decoded_len != '1)
            decoded_len++;
    endfunction

    function automatic void abort_string(logic [2:0] code);
        pend_ok = 1'b0;
        pend_hi = '0;
        st      = ST_WAIT;
        push_beat(KIND_ERROR, 8'h00, code, '0, 1'b0);
    endfunction

    function automatic void emit_3byte(logic [15:0] v);
        emit_byte({4'he, v[15:12]});
        emit_byte({2'b10, v[11:6]});
        emit_byte({2'b10, v[5:0]});
    endfunction

    function automatic void flush_pending();
        if (pend_ok)
        begin
            emit_3byte(pend_hi);
            pend_ok = 1'b0;
            pend_hi = '0;
        end
    endfunction

    function automatic void close_unicode(logic [15:0] v);
        logic [20:0] cp;
        if (v >= 16'hdc00 && v < 16'he000 && pend_ok)
        begin
            // merge the held high half with this low half
            cp = 21'h10000 + {1'b0, pend_hi[9:0], v[9:0]};
            pend_ok = 1'b0;
            pend_hi = '0;
            emit_byte({5'b11110, cp[20:18]});
            emit_byte({2'b10, cp[17:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
            return;
        end
        flush_pending();
        if (v < 16'h0080)
            emit_byte(v[7:0]);
        else if (v < 16'h0800)
        begin
            emit_byte({3'b110, v[10:6]});
            emit_byte({2'b10, v[5:0]});
        end
        else if (v >= 16'hd800 && v < 16'hdc00)
        begin
            pend_hi = v;
            pend_ok = 1'b1;
        end
        else
            emit_3byte(v);
    endfunction

    function automatic void text_char(logic [7:0] c);
        if (c == BSLASH)
        begin
            st = ST_ESCAPE;
            return;
        end
        if (c == QUOTE)
        begin
            flush_pending();
            push_beat(KIND_DONE, 8'h00, ERR_NONE, decoded_len, decoded_len > SHORT_MAX);
            st = ST_WAIT;
            return;
        end
        if (c < 8'h20)
        begin
            abort_string(ERR_CONTROL);
            return;
        end
        if (!c[7] || !validate_on)
        begin
            flush_pending();
            emit_byte(c);
            return;
        end
        if (c[7:5] == 3'b110)
            follow_cnt = 2'd1;
        else if (c[7:4] == 4'b1110)
            follow_cnt = 2'd2;
        else if (c[7:3] == 5'b11110)
            follow_cnt = 2'd3;
        else
        begin
            abort_string(ERR_UTF8);
            return;
        end
        flush_pending();
        emit_byte(c);
        st = ST_UTF8;
    endfunction

    function automatic void escape_char(logic [7:0] c);
        logic [7:0] b;
        case (c)
            QUOTE, "/", BSLASH: b = c;
            "b": b = 8'h08;
            "f": b = 8'h0c;
            "n": b = 8'h0a;
            "r": b = 8'h0d;
            "t": b = 8'h09;
            "u":
            begin
                hex_digits = '0;
                hex_acc    = '0;
                st         = ST_HEX;
                return;
            end
            default:
            begin
                abort_string(ERR_ESCAPE);
                return;
            end
        endcase
        flush_pending();
        emit_byte(b);
        st = ST_TEXT;
    endfunction

    function automatic void hex_char(logic [7:0] c);
        logic [3:0] d;
        if (c >= "0" && c <= "9")
            d = c[3:0];
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            d = c[3:0] + 4'd9;
        else
        begin
            abort_string(ERR_HEX);
            return;
        end
        hex_acc = {hex_acc[11:0], d};
        hex_digits++;
        if (hex_digits >= 3'd4)
        begin
            hex_digits = '0;
            st = ST_TEXT;
            close_unicode(hex_acc);
            hex_acc = '0;
        end
    endfunction

    function automatic void predict_item(in_item_t it);
        int        first;
        out_item_t tail;
        first = expected_q.size();
        if (st == ST_WAIT)
        begin
            if (!it.stream_end && it.in_byte == QUOTE)
            begin
                st          = ST_TEXT;
                hex_digits  = '0;
                hex_acc     = '0;
                pend_hi     = '0;
                pend_ok     = 1'b0;
                follow_cnt  = '0;
                decoded_len = '0;
            end
            return;
        end
        if (it.stream_end)
        begin
            case (st)
                ST_ESCAPE: abort_string(ERR_ESCAPE);
                ST_UTF8:   abort_string(ERR_TRUNCATED);
                default:   abort_string(ERR_UNFINISHED);
            endcase
        end
        else
        begin
            case (st)
                ST_ESCAPE: escape_char(it.in_byte);
                ST_HEX:    hex_char(it.in_byte);
                ST_UTF8:
                begin
                    if (it.in_byte[7:6] != 2'b10)
                        abort_string(ERR_UTF8);
                    else
                    begin
                        emit_byte(it.in_byte);
                        follow_cnt--;
                        if (follow_cnt == '0)
                            st = ST_TEXT;
                    end
                end
                default:
                begin
                    st = ST_TEXT;
                    text_char(it.in_byte);
                end
            endcase
        end
        if (expected_q.size() > first)
        begin
            tail = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic string fmt_beat(out_item_t b);
        return $sformatf("kind=%0d byte=%02h code=%0d len=%0d long=%0b last=%0b",
                         b.out_kind, b.out_byte, b.error_code, b.string_length,
                         b.long_header, b.last);
    endfunction

    function automatic void check_beat(out_item_t got);
        out_item_t want;
        beats_seen++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected beat %s", fmt_beat(got));
            return;
        end
        want = expected_q.pop_front();
        if (want.out_kind == KIND_DONE)
        begin
            done_seen++;
            if (want.long_header)
                long_seen++;
        end
        else if (want.out_kind == KIND_ERROR)
            errors_seen++;
        if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
            got.error_code !== want.error_code || got.string_length !== want.string_length ||
            got.long_header !== want.long_header || got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR at %0t: expected %s", $realtime, fmt_beat(want));
                $display("    got %s", fmt_beat(got));
            end
        end
    endfunction

    // predict first so an accepted byte is queued before any beat it could cause
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_item(in_data);
            if (out_valid && out_ready)
                check_beat(out_data);
        end
    end

    initial
    begin : sink_stall
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_item(logic [7:0] b, logic e);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, stream_end: e};
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        // bytes with no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_validate(logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        validate_on = v;
    endtask

    function automatic logic [7:0] hex_digit_char(logic [3:0] d);
        if (d < 4'd10)
            return 8'h30 + d;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + d - 8'd10;
    endfunction

    function automatic logic [7:0] escape_letter(int idx);
        case (idx)
            0:       return QUOTE;
            1:       return "/";
            2:       return BSLASH;
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    task automatic send_codepoint(logic [15:0] v);
        send_item(BSLASH, 1'b0);
        send_item("u", 1'b0);
        send_item(hex_digit_char(v[15:12]), 1'b0);
        send_item(hex_digit_char(v[11:8]), 1'b0);
        send_item(hex_digit_char(v[7:4]), 1'b0);
        send_item(hex_digit_char(v[3:0]), 1'b0);
    endtask

    // est is a lower bound on the decoded bytes of the escape
    task automatic send_random_codepoint(output int est);
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:
            begin
                v = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 16'h7f));
                est = 1;
            end
            1:
            begin
                v = 16'($urandom_range(16'h80, 16'h7ff));
                est = 2;
            end
            2:
            begin
                if ($urandom_range(0, 7) == 0)
                    v = 16'hffff;
                else if ($urandom_range(0, 1))
                    v = 16'($urandom_range(16'h800, 16'hd7ff));
                else
                    v = 16'($urandom_range(16'he000, 16'hffff));
                est = 3;
            end
            3:
            begin
                v = 16'($urandom_range(16'hd800, 16'hdbff));
                est = 1;
            end
            4:
            begin
                v = 16'($urandom_range(16'hdc00, 16'hdfff));
                est = 3;
            end
            default:
            begin
                send_codepoint(16'($urandom_range(16'hd800, 16'hdbff)));
                v = 16'($urandom_range(16'hdc00, 16'hdfff));
                est = 4;
            end
        endcase
        send_codepoint(v);
    endtask

    task automatic send_random_piece(bit clean, output int est);
        int         pick;
        int         n;
        logic [7:0] b;
        est  = 0;
        pick = $urandom_range(0, clean ? 84 : 99);
        if (pick < 30)
        begin
            do b = 8'($urandom_range(8'h20, 8'h7e)); while (b == QUOTE || b == BSLASH);
            send_item(b, 1'b0);
            est = 1;
        end
        else if (pick < 45)
        begin
            send_item(BSLASH, 1'b0);
            send_item(escape_letter($urandom_range(0, 7)), 1'b0);
            est = 1;
        end
        else if (pick < 65)
            send_random_codepoint(est);
        else if (pick < 85)
        begin
            n = $urandom_range(1, 3);
            case (n)
                1:       b = 8'($urandom_range(8'hc0, 8'hdf));
                2:       b = 8'($urandom_range(8'he0, 8'hef));
                default: b = 8'($urandom_range(8'hf0, 8'hf7));
            endcase
            send_item(b, 1'b0);
            repeat (n) send_item(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
            est = n + 1;
        end
        else
        begin
            // malformed input
            case ($urandom_range(0, 5))
                0: send_item(8'($urandom), 1'b0);
                1: send_item(8'($urandom), 1'b1);
                2:
                begin
                    send_item(BSLASH, 1'b0);
                    send_item(8'($urandom), 1'b0);
                end
                3:
                begin
                    send_item(BSLASH, 1'b0);
                    send_item("u", 1'b0);
                    repeat ($urandom_range(0, 3)) send_item(hex_digit_char(4'($urandom)), 1'b0);
                    send_item(8'($urandom), $urandom_range(0, 3) == 0);
                end
                4:
                begin
                    send_item(8'($urandom_range(8'h80, 8'hff)), 1'b0);
                    repeat ($urandom_range(0, 2))
                        send_item(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
                    send_item(8'($urandom), $urandom_range(0, 3) == 0);
                end
                default: send_item(8'($urandom_range(0, 8'h1f)), 1'b0);
            endcase
        end
    endtask

    task automatic send_random_string(bit long_body);
        int est;
        int total;
        // end of input closes whatever is open; it is dropped while waiting
        send_item(8'($urandom), 1'b1);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'($urandom_range(0, 1)));
        send_item(QUOTE, 1'b0);
        if (long_body)
        begin
            total = 0;
            while (total < 130)
            begin
                send_random_piece(1'b1, est);
                total += est;
            end
        end
        else
            repeat ($urandom_range(0, 10)) send_random_piece(1'b0, est);
        case ($urandom_range(0, 19))
            0, 1:    send_item(8'($urandom), 1'b1);
            2:       ;
            default: send_item(QUOTE, 1'b0);
        endcase
    endtask

    task automatic run_random_strings(int n_items, bit with_long);
        int stop_at;
        stop_at = items_sent + n_items;
        if (with_long)
            send_random_string(1'b1);
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 14) == 0)
                wait_drained();
            send_random_string(1'b0);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // validation off from reset: high bytes copied, held surrogate flushed on done
    task automatic test_copy_mode();
        send_item(8'hff, 1'b0);
        send_item(BSLASH, 1'b0);
        send_item("n", 1'b0);
        send_codepoint(16'hd800);
        send_item(QUOTE, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(QUOTE, 1'b0);
        send_item(QUOTE, 1'b0);
        send_item(QUOTE, 1'b0);
        send_item(8'h00, 1'b0);
    endtask

    task automatic test_surrogate_pair();
        send_item(QUOTE, 1'b0);
        send_codepoint(16'hd83d);
        send_codepoint(16'hde00);
        send_item(QUOTE, 1'b0);
    endtask

    task automatic test_utf8_checks();
        send_item(QUOTE, 1'b0);
        send_item(8'hc3, 1'b0);
        send_item(8'ha9, 1'b0);
        send_item(8'he2, 1'b0);
        send_item(8'h82, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(QUOTE, 1'b0);
        send_item(8'h80, 1'b0);
    endtask

    task automatic test_random_checked();
        wait_drained();
        write_validate(1'b1);
        run_random_strings(150, 1'b1);
    endtask

    task automatic test_random_copy();
        wait_drained();
        write_validate(1'b0);
        run_random_strings(60, 1'b0);
    endtask

    task automatic test_random_no_idle();
        wait_drained();
        write_validate(1'b1);
        idling_on = 1'b0;
        run_random_strings(60, 1'b0);
    endtask

    initial
    begin : main
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_copy_mode();
        test_surrogate_pair();
        wait_drained();
        write_validate(1'b1);
        test_utf8_checks();
        test_random_checked();
        test_random_copy();
        test_random_no_idle();

        wait_drained();
        repeat (16) @(posedge clk);

        $display("Sent %0d input beats: escapes, surrogates, UTF-8 and malformed strings,",
                 items_sent);
        $display("with checking on and off; %0d result beats: %0d done (%0d long), %0d error",
                 beats_seen, done_seen, long_seen, errors_seen);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

endmodule
